// File: design/lpe_pkg.sv
// Package for the lexicographic permutation engine: codes, states and fixed widths.
package lpe_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 4;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_NEXT   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STAT_CHAR      = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_EXHAUSTED = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_APP_RD,
        ST_APP_CMP,
        ST_INIT,
        ST_PIV_LOAD,
        ST_PIV_CMP,
        ST_SUC_CMP,
        ST_SWAP,
        ST_REV_RDLO,
        ST_REV_RDHI,
        ST_REV_WLO,
        ST_REV_WHI,
        ST_EMIT_START,
        ST_EMIT_RDI,
        ST_EMIT_RDS,
        ST_EMIT_OUT,
        ST_RESULT
    } state_t;

endpackage

// File: design/lpe_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
module lpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lexicographic_permutation_engine.sv
// Top level of the lexicographic permutation engine: sequencer, stores and output register.
//
// Usage: each input word carries a request. Clear (no result) empties the store. Append
// inserts s_char_in into the ascending store after any equal bytes, moving each stored
// byte greater than the new one up one slot, and gives no result, or one overflow result
// if the store already holds MAX_LEN bytes. Next emits one permutation of the stored bytes,
// one result word per character with m_last_of_run on the final one; permutations run over
// positions in lexicographic order, so repeated bytes give repeated permutations. An empty
// store gives one empty-permutation result, and once the final permutation is passed every
// next reports exhausted until a clear or append. The first next after a load writes the
// identity order; later ones scan from the right for the pivot, then for the successor,
// swap the two and reverse the suffix one pair at a time. Emission then reads the index
// order, then the sorted byte, then loads the result register, for each character in turn;
// while m_ready holds a word back, emission waits. This step-by-step pace comes from the
// single read port of each of the two stores, index order and sorted bytes, which the
// sequencer walks one entry per step. s_ready is high only while the sequencer is idle; the
// result register lets a new request be taken while the last word of the previous one still
// waits for m_ready. The stores need no clearing pass after reset.
module lexicographic_permutation_engine #(
    parameter int MAX_LEN = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_req_type,
    input  logic [lpe_pkg::CHAR_W-1:0] s_char_in,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lpe_pkg::CHAR_W-1:0] m_char_out,
    output logic [lpe_pkg::POS_W-1:0]  m_char_position,
    output logic                       m_last_of_run,
    output logic [1:0]                 m_status
);

    // count holds 0..MAX_LEN, indices 0..MAX_LEN-1
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    lpe_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             started_reg, started_next;
    logic             exh_reg, exh_next;
    // general walking pointer: insertion slot, i+1 during pivot scan, j, lo, emit position
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] piv_pos_reg, piv_pos_next;
    logic [IDX_W-1:0] piv_reg, piv_next;
    logic [IDX_W-1:0] tmp_reg, tmp_next;
    logic [lpe_pkg::CHAR_W-1:0] char_reg, char_next;
    lpe_pkg::stat_t   res_stat_reg, res_stat_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [lpe_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic [lpe_pkg::POS_W-1:0]  out_pos_reg, out_pos_next;
    logic                       out_last_reg, out_last_next;
    lpe_pkg::stat_t             out_stat_reg, out_stat_next;
    logic                       out_free;

    // store ports
    logic                       io_we, io_re;
    logic [IDX_W-1:0]           io_waddr, io_raddr, io_wdata, io_rdata;
    logic                       sc_we, sc_re;
    logic [IDX_W-1:0]           sc_waddr, sc_raddr;
    logic [lpe_pkg::CHAR_W-1:0] sc_wdata, sc_rdata;

    logic [CNT_W-1:0] ptr_m1, ptr_m2, ptr_p1, cnt_m1;

    lpe_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_index_order (
        .aclk  (aclk),
        .we    (io_we),
        .waddr (io_waddr),
        .wdata (io_wdata),
        .re    (io_re),
        .raddr (io_raddr),
        .rdata (io_rdata)
    );

    lpe_ram #(.WIDTH(lpe_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_sorted_chars (
        .aclk  (aclk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .re    (sc_re),
        .raddr (sc_raddr),
        .rdata (sc_rdata)
    );

    assign ptr_m1   = CNT_W'(ptr_reg - 1'b1);
    assign ptr_m2   = CNT_W'(ptr_reg - 2'd2);
    assign ptr_p1   = CNT_W'(ptr_reg + 1'b1);
    assign cnt_m1   = CNT_W'(count_reg - 1'b1);
    assign out_free = !out_valid_reg || m_ready;

    assign s_ready         = (state_reg == lpe_pkg::ST_IDLE);
    assign m_valid         = out_valid_reg;
    assign m_char_out      = out_char_reg;
    assign m_char_position = out_pos_reg;
    assign m_last_of_run   = out_last_reg;
    assign m_status        = out_stat_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        started_next   = started_reg;
        exh_next       = exh_reg;
        ptr_next       = ptr_reg;
        hi_next        = hi_reg;
        piv_pos_next   = piv_pos_reg;
        piv_next       = piv_reg;
        tmp_next       = tmp_reg;
        char_next      = char_reg;
        res_stat_next  = res_stat_reg;

        out_valid_next = out_valid_reg && !m_ready;
        out_char_next  = out_char_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_stat_next  = out_stat_reg;

        io_we    = 1'b0;
        io_waddr = ptr_reg[IDX_W-1:0];
        io_wdata = piv_reg;
        io_re    = 1'b0;
        io_raddr = ptr_reg[IDX_W-1:0];
        sc_we    = 1'b0;
        sc_waddr = ptr_reg[IDX_W-1:0];
        sc_wdata = char_reg;
        sc_re    = 1'b0;
        sc_raddr = io_rdata;

        case (state_reg)
            lpe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_req_type)
                        lpe_pkg::REQ_CLEAR: begin
                            count_next   = '0;
                            started_next = 1'b0;
                            exh_next     = 1'b0;
                        end
                        lpe_pkg::REQ_APPEND: begin
                            if (count_reg >= CNT_W'(MAX_LEN)) begin
                                res_stat_next = lpe_pkg::STAT_OVERFLOW;
                                state_next    = lpe_pkg::ST_RESULT;
                            end else begin
                                char_next    = s_char_in;
                                ptr_next     = count_reg;
                                started_next = 1'b0;
                                exh_next     = 1'b0;
                                state_next   = lpe_pkg::ST_APP_RD;
                            end
                        end
                        lpe_pkg::REQ_NEXT: begin
                            if (exh_reg) begin
                                res_stat_next = lpe_pkg::STAT_EXHAUSTED;
                                state_next    = lpe_pkg::ST_RESULT;
                            end else if (!started_reg) begin
                                ptr_next   = '0;
                                state_next = lpe_pkg::ST_INIT;
                            end else if (count_reg < CNT_W'(2)) begin
                                // a single order has no successor
                                exh_next      = 1'b1;
                                res_stat_next = lpe_pkg::STAT_EXHAUSTED;
                                state_next    = lpe_pkg::ST_RESULT;
                            end else begin
                                io_re      = 1'b1;
                                io_raddr   = cnt_m1[IDX_W-1:0];
                                ptr_next   = cnt_m1;
                                state_next = lpe_pkg::ST_PIV_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // insertion: shift larger bytes up one slot, then drop the new byte in
            lpe_pkg::ST_APP_RD: begin
                if (ptr_reg == '0) begin
                    sc_we      = 1'b1;
                    sc_wdata   = char_reg;
                    count_next = CNT_W'(count_reg + 1'b1);
                    state_next = lpe_pkg::ST_IDLE;
                end else begin
                    sc_re      = 1'b1;
                    sc_raddr   = ptr_m1[IDX_W-1:0];
                    state_next = lpe_pkg::ST_APP_CMP;
                end
            end
            lpe_pkg::ST_APP_CMP: begin
                sc_we = 1'b1;
                if (sc_rdata > char_reg) begin
                    sc_wdata   = sc_rdata;
                    ptr_next   = ptr_m1;
                    state_next = lpe_pkg::ST_APP_RD;
                end else begin
                    sc_wdata   = char_reg;
                    count_next = CNT_W'(count_reg + 1'b1);
                    state_next = lpe_pkg::ST_IDLE;
                end
            end

            // identity order
            lpe_pkg::ST_INIT: begin
                if (ptr_reg < count_reg) begin
                    io_we    = 1'b1;
                    io_wdata = ptr_reg[IDX_W-1:0];
                    ptr_next = ptr_p1;
                end else begin
                    started_next = 1'b1;
                    state_next   = lpe_pkg::ST_EMIT_START;
                end
            end

            // pivot scan from the right: tmp holds order[i+1]
            lpe_pkg::ST_PIV_LOAD: begin
                tmp_next   = io_rdata;
                io_re      = 1'b1;
                io_raddr   = ptr_m1[IDX_W-1:0];
                state_next = lpe_pkg::ST_PIV_CMP;
            end
            lpe_pkg::ST_PIV_CMP: begin
                if (io_rdata >= tmp_reg) begin
                    if (ptr_reg == CNT_W'(1)) begin
                        // last permutation passed
                        exh_next      = 1'b1;
                        res_stat_next = lpe_pkg::STAT_EXHAUSTED;
                        state_next    = lpe_pkg::ST_RESULT;
                    end else begin
                        tmp_next = io_rdata;
                        ptr_next = ptr_m1;
                        io_re    = 1'b1;
                        io_raddr = ptr_m2[IDX_W-1:0];
                    end
                end else begin
                    piv_next     = io_rdata;
                    piv_pos_next = ptr_m1;
                    io_re        = 1'b1;
                    io_raddr     = cnt_m1[IDX_W-1:0];
                    ptr_next     = cnt_m1;
                    state_next   = lpe_pkg::ST_SUC_CMP;
                end
            end

            // rightmost entry above the pivot
            lpe_pkg::ST_SUC_CMP: begin
                if (io_rdata <= piv_reg) begin
                    ptr_next = ptr_m1;
                    io_re    = 1'b1;
                    io_raddr = ptr_m1[IDX_W-1:0];
                end else begin
                    io_we      = 1'b1;
                    io_wdata   = piv_reg;
                    tmp_next   = io_rdata;
                    state_next = lpe_pkg::ST_SWAP;
                end
            end
            lpe_pkg::ST_SWAP: begin
                io_we      = 1'b1;
                io_waddr   = piv_pos_reg[IDX_W-1:0];
                io_wdata   = tmp_reg;
                ptr_next   = CNT_W'(piv_pos_reg + 1'b1);
                hi_next    = cnt_m1;
                state_next = lpe_pkg::ST_REV_RDLO;
            end

            // suffix reversal, one pair per pass
            lpe_pkg::ST_REV_RDLO: begin
                if (ptr_reg < hi_reg) begin
                    io_re      = 1'b1;
                    state_next = lpe_pkg::ST_REV_RDHI;
                end else begin
                    state_next = lpe_pkg::ST_EMIT_START;
                end
            end
            lpe_pkg::ST_REV_RDHI: begin
                tmp_next   = io_rdata;
                io_re      = 1'b1;
                io_raddr   = hi_reg[IDX_W-1:0];
                state_next = lpe_pkg::ST_REV_WLO;
            end
            lpe_pkg::ST_REV_WLO: begin
                io_we      = 1'b1;
                io_wdata   = io_rdata;
                state_next = lpe_pkg::ST_REV_WHI;
            end
            lpe_pkg::ST_REV_WHI: begin
                io_we      = 1'b1;
                io_waddr   = hi_reg[IDX_W-1:0];
                io_wdata   = tmp_reg;
                ptr_next   = ptr_p1;
                hi_next    = CNT_W'(hi_reg - 1'b1);
                state_next = lpe_pkg::ST_REV_RDLO;
            end

            // emission: order[p] -> sorted[order[p]] -> result register
            lpe_pkg::ST_EMIT_START: begin
                ptr_next = '0;
                if (count_reg == '0) begin
                    res_stat_next = lpe_pkg::STAT_EMPTY;
                    state_next    = lpe_pkg::ST_RESULT;
                end else begin
                    state_next = lpe_pkg::ST_EMIT_RDI;
                end
            end
            lpe_pkg::ST_EMIT_RDI: begin
                io_re      = 1'b1;
                state_next = lpe_pkg::ST_EMIT_RDS;
            end
            lpe_pkg::ST_EMIT_RDS: begin
                sc_re      = 1'b1;
                sc_raddr   = io_rdata;
                state_next = lpe_pkg::ST_EMIT_OUT;
            end
            lpe_pkg::ST_EMIT_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = sc_rdata;
                    out_pos_next   = lpe_pkg::POS_W'(ptr_reg);
                    out_last_next  = (ptr_p1 == count_reg);
                    out_stat_next  = lpe_pkg::STAT_CHAR;
                    ptr_next       = ptr_p1;
                    state_next     = (ptr_p1 == count_reg) ? lpe_pkg::ST_IDLE
                                                           : lpe_pkg::ST_EMIT_RDI;
                end
            end

            // single status word
            lpe_pkg::ST_RESULT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    out_pos_next   = '0;
                    out_last_next  = 1'b1;
                    out_stat_next  = res_stat_reg;
                    state_next     = lpe_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lpe_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lpe_pkg::ST_IDLE;
            count_reg     <= '0;
            started_reg   <= 1'b0;
            exh_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            started_reg   <= started_next;
            exh_reg       <= exh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and payload
    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        hi_reg       <= hi_next;
        piv_pos_reg  <= piv_pos_next;
        piv_reg      <= piv_next;
        tmp_reg      <= tmp_next;
        char_reg     <= char_next;
        res_stat_reg <= res_stat_next;
        out_char_reg <= out_char_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
        out_stat_reg <= out_stat_next;
    end

endmodule

// File: design/lpe_checker.sv
// Port-level checker for the permutation engine, bound to the top level.
module lpe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_req_type,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char_out,
    input logic [3:0] m_char_position,
    input logic       m_last_of_run,
    input logic [1:0] m_status
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_out)
            && $stable(m_char_position) && $stable(m_last_of_run) && $stable(m_status))
        else $error("result word changed while stalled");

    // status words are single and blank
    a_status_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != lpe_pkg::STAT_CHAR |->
            m_last_of_run && m_char_out == 8'd0 && m_char_position == 4'd0)
        else $error("status word not a blank last word");

    // mid-run the engine is still busy
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lpe_pkg::STAT_CHAR && !m_last_of_run |-> !s_ready)
        else $error("request taken in the middle of a permutation");

    // an append always occupies the sequencer
    a_append_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == lpe_pkg::REQ_APPEND |=> !s_ready)
        else $error("append finished without work");

    // nothing pending out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lexicographic_permutation_engine lpe_checker u_lpe_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_req_type      (s_req_type),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_char_out      (m_char_out),
    .m_char_position (m_char_position),
    .m_last_of_run   (m_last_of_run),
    .m_status        (m_status)
);

// File: bench/lexicographic_permutation_engine_tb.sv
// Self-checking bench for the lexicographic permutation engine: stimulus, prediction, checks.
module lexicographic_permutation_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_W         = lpe_pkg::CHAR_W;
    localparam int POS_W          = lpe_pkg::POS_W;
    localparam int DEPTH          = 12;       // store depth given to the block
    localparam int TOTAL_REQUESTS = 380;      // words that do something, directed part included
    localparam int CYCLE_LIMIT    = 300_000;  // several times the slowest legal run
    localparam int SETTLE_CYCLES  = 64;       // longest silent request is a deep append
    localparam logic [1:0] REQ_UNUSED = 2'd3; // selector the block ignores

    // One result word as the block should present it.
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic              last;
        lpe_pkg::stat_t    status;
    } perm_word_t;

    // Predicts the permutation words of each accepted request and checks them on arrival.
    class permutation_checker;
        logic [CHAR_W-1:0] store_bytes[DEPTH];  // ascending byte store
        logic [POS_W-1:0]  perm_order[DEPTH];   // current order of store positions
        logic [4:0]        n_stored;
        bit                begun;
        bit                spent;
        perm_word_t        pending_words[$];
        int                mismatches;

        function new();
            foreach (store_bytes[k]) store_bytes[k] = '0;
            foreach (perm_order[k]) perm_order[k] = '0;
            n_stored    = '0;
            begun       = 1'b0;
            spent       = 1'b0;
            mismatches  = 0;
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction

        function void queue_word(logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos, logic last,
                                 lpe_pkg::stat_t st);
            perm_word_t w;
            w.ch     = ch;
            w.pos    = pos;
            w.last   = last;
            w.status = st;
            pending_words.push_back(w);
        endfunction

        // Next order of positions; 0 once the descending order has been reached.
        function bit step_order();
            int i;
            int j;
            int lo;
            int hi;
            logic [POS_W-1:0] t;
            i = int'(n_stored) - 2;
            while (i >= 0 && perm_order[i] >= perm_order[i+1]) i--;
            if (i < 0) return 1'b0;
            j = int'(n_stored) - 1;
            while (perm_order[j] <= perm_order[i]) j--;
            t             = perm_order[i];
            perm_order[i] = perm_order[j];
            perm_order[j] = t;
            lo = i + 1;
            hi = int'(n_stored) - 1;
            while (lo < hi) begin
                t              = perm_order[lo];
                perm_order[lo] = perm_order[hi];
                perm_order[hi] = t;
                lo++;
                hi--;
            end
            return 1'b1;
        endfunction

        function void predict_request(logic [1:0] req, logic [CHAR_W-1:0] ch);
            int p;
            case (req)
                lpe_pkg::REQ_CLEAR: begin
                    n_stored = '0;
                    begun    = 1'b0;
                    spent    = 1'b0;
                end
                lpe_pkg::REQ_APPEND: begin
                    if (n_stored >= DEPTH) begin
                        queue_word('0, '0, 1'b1, lpe_pkg::STAT_OVERFLOW);
                        return;
                    end
                    p = int'(n_stored);
                    while (p > 0 && store_bytes[p-1] > ch) begin
                        store_bytes[p] = store_bytes[p-1];
                        p--;
                    end
                    store_bytes[p] = ch;
                    n_stored++;
                    begun = 1'b0;
                    spent = 1'b0;
                end
                lpe_pkg::REQ_NEXT: begin
                    if (spent) begin
                        queue_word('0, '0, 1'b1, lpe_pkg::STAT_EXHAUSTED);
                        return;
                    end
                    if (!begun) begin
                        for (p = 0; p < int'(n_stored); p++) perm_order[p] = POS_W'(p);
                        begun = 1'b1;
                    end else if (!step_order()) begin
                        spent = 1'b1;
                        queue_word('0, '0, 1'b1, lpe_pkg::STAT_EXHAUSTED);
                        return;
                    end
                    if (n_stored == 0) begin
                        queue_word('0, '0, 1'b1, lpe_pkg::STAT_EMPTY);
                        return;
                    end
                    for (p = 0; p < int'(n_stored); p++)
                        queue_word(store_bytes[perm_order[p] % DEPTH], POS_W'(p),
                                   p + 1 == int'(n_stored), lpe_pkg::STAT_CHAR);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos, logic last,
                          logic [1:0] st);
            perm_word_t want;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf(
                    "word with nothing expected: ch %0h pos %0d last %0b st %0d",
                    ch, pos, last, st));
                return;
            end
            want = pending_words.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("char_out %0h, expected %0h", ch, want.ch));
            if (pos !== want.pos)
                report_mismatch($sformatf("char_position %0d, expected %0d", pos, want.pos));
            if (last !== want.last)
                report_mismatch($sformatf("last_of_run %0b, expected %0b", last, want.last));
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_req_type = lpe_pkg::REQ_CLEAR;
    logic [CHAR_W-1:0] s_char_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CHAR_W-1:0] m_char_out;
    logic [POS_W-1:0]  m_char_position;
    logic              m_last_of_run;
    logic [1:0]        m_status;

    permutation_checker chk = new();
    int  requests_sent = 0;    // accepted words other than the ignored selector
    int  cycle_count   = 0;
    bit  no_idle       = 1'b0; // set for the stretch where neither side pauses

    lexicographic_permutation_engine #(.MAX_LEN(DEPTH)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_char_in       (s_char_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_out      (m_char_out),
        .m_char_position (m_char_position),
        .m_last_of_run   (m_last_of_run),
        .m_status        (m_status)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hang anywhere ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    // Receiver back-pressure: m_ready dropped at random about 14 percent of the time, never in the quiet stretch.
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 14);
    end

    // Result monitor; outputs are read as they stood before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            chk.check_result(m_char_out, m_char_position, m_last_of_run, m_status);
    end

    // Offer one request word, with a random gap first, and hold it until taken.
    task automatic send_word(input logic [1:0] req, input logic [CHAR_W-1:0] ch);
        while (!no_idle && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_char_in  <= ch;
        do @(posedge aclk); while (!s_ready);
        chk.predict_request(req, ch);
        if (req != REQ_UNUSED) requests_sent++;
    endtask

    // Sender stops until the block has delivered every word owed.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chk.outstanding() != 0);
    endtask

    // Mostly a narrow alphabet so that repeated bytes are common.
    function automatic logic [CHAR_W-1:0] pick_byte();
        if ($urandom_range(1) == 0) return CHAR_W'(8'h41 + $urandom_range(0, 3));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    initial begin
        int          shape;
        int          n_load;
        int          n_next;
        int          perms;
        bit          drained_once;
        logic [1:0]  sel;

        drained_once = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---
        // empty store: one empty permutation, then exhausted for good
        send_word(lpe_pkg::REQ_NEXT, 8'h00);
        send_word(lpe_pkg::REQ_NEXT, 8'hFF);
        // byte extremes, inserted out of order; both orders, then exhausted twice
        send_word(lpe_pkg::REQ_APPEND, 8'hFF);
        send_word(lpe_pkg::REQ_APPEND, 8'h00);
        send_word(lpe_pkg::REQ_NEXT, 8'h00);
        send_word(lpe_pkg::REQ_NEXT, 8'h00);
        send_word(lpe_pkg::REQ_NEXT, 8'h00);
        send_word(lpe_pkg::REQ_NEXT, 8'h00);
        // unused selector is dropped without a word back
        send_word(REQ_UNUSED, 8'h5A);
        // duplicate byte goes after its equal and restarts the walk
        send_word(lpe_pkg::REQ_APPEND, 8'hFF);
        send_word(lpe_pkg::REQ_NEXT, 8'h00);
        // fill to the brim in descending order so every insert after the first shifts the store
        send_word(lpe_pkg::REQ_CLEAR, 8'hA5);
        for (int k = 0; k < DEPTH; k++)
            send_word(lpe_pkg::REQ_APPEND, CHAR_W'(8'hF0 - 8'h15 * k));
        // one more than fits: overflow, store untouched
        send_word(lpe_pkg::REQ_APPEND, 8'h80);
        send_word(lpe_pkg::REQ_NEXT, 8'h00);
        send_word(lpe_pkg::REQ_NEXT, 8'h00);

        // --- random part ---
        while (requests_sent < TOTAL_REQUESTS) begin
            no_idle = (requests_sent >= 150 && requests_sent < 230);
            if ((!drained_once && requests_sent >= 100) || $urandom_range(19) == 0) begin
                hold_until_drained();
                drained_once = 1'b1;
            end
            shape = $urandom_range(99);
            if (shape < 65) begin
                // well-formed: clear, load, walk; short loads run to exhaustion
                if ($urandom_range(9) != 0) send_word(lpe_pkg::REQ_CLEAR, pick_byte());
                shape = $urandom_range(99);
                if (shape < 70)      n_load = $urandom_range(0, 4);
                else if (shape < 92) n_load = $urandom_range(5, DEPTH);
                else                 n_load = $urandom_range(DEPTH, DEPTH + 2);
                for (int k = 0; k < n_load; k++) send_word(lpe_pkg::REQ_APPEND, pick_byte());
                if (n_load <= 4) begin
                    perms = 1;
                    for (int f = 2; f <= n_load; f++) perms *= f;
                    n_next = perms + $urandom_range(1, 2);
                end else begin
                    n_next = $urandom_range(1, 5);
                end
                for (int k = 0; k < n_next; k++)
                    send_word(lpe_pkg::REQ_NEXT, CHAR_W'($urandom_range(0, 255)));
            end else if (shape < 85) begin
                // noise: any selector, any byte
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
            end else begin
                // broken walk: appends land mid-walk and restart it
                repeat ($urandom_range(2, 6)) begin
                    sel = ($urandom_range(1) == 0) ? lpe_pkg::REQ_APPEND : lpe_pkg::REQ_NEXT;
                    send_word(sel, pick_byte());
                end
            end
        end
        no_idle = 1'b0;

        // --- wind-down: everything owed must arrive, and nothing after it ---
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (chk.mismatches == 0 && chk.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/lpe_pkg.sv
design/lpe_ram.sv
design/lexicographic_permutation_engine.sv
design/lpe_checker.sv
bench/lexicographic_permutation_engine_tb.sv
